// File: rtl/core/timer_expiry_queue_assert.svh
// Assertion macros shared by the checker.
`ifndef TIMER_EXPIRY_QUEUE_ASSERT_SVH
`define TIMER_EXPIRY_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TEQ_ASSERT_IMPL(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define TEQ_ASSERT_NEXT(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// File: rtl/core/tmq_pkg.sv
package tmq_pkg;

    localparam int unsigned TIMER_SLOTS_DEF     = 16;
    localparam logic [31:0] DEFAULT_TIMEOUT_RST = 32'd10000;
    localparam logic [31:0] IDENT_RST           = 32'd1;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_TICK   = 2'd2,
        ACT_QUERY  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_ADD_ACK    = 2'd0,
        KIND_DELETE_ACK = 2'd1,
        KIND_EXPIRED    = 2'd2,
        KIND_DURATION   = 2'd3
    } kind_t;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_FULL       = 2'd1;
    localparam logic [1:0] STATUS_NOT_ACTIVE = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_REARM
    } state_t;

    typedef struct packed {
        logic [31:0] expiry;
        logic [30:0] interval;
        logic [31:0] ident;
    } slot_t;

    // Broadcast to every cell in the row.
    typedef struct packed {
        cell_op_t op;
        slot_t    key;
    } cell_ctl_t;

endpackage

// File: rtl/core/tmq_cell.sv
module tmq_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  tmq_pkg::cell_ctl_t ctl,
    input  tmq_pkg::slot_t    left_data,
    input  logic              left_valid,
    input  logic              left_ins,
    input  logic              left_chain,
    input  tmq_pkg::slot_t    right_data,
    input  logic              right_valid,
    output tmq_pkg::slot_t    data,
    output logic              valid,
    output logic              ins,
    output logic              chain
);

    tmq_pkg::slot_t data_reg, data_next;
    logic           valid_reg, valid_next;

    // ins: new key belongs at or before this cell; chain: a removal covers this cell
    always_comb begin
        ins   = !valid_reg || (data_reg.expiry > ctl.key.expiry);
        chain = left_chain || (valid_reg && (data_reg.ident == ctl.key.ident));
        data_next  = data_reg;
        valid_next = valid_reg;
        unique case (ctl.op)
            tmq_pkg::CELL_INSERT: begin
                if (left_ins) begin
                    data_next  = left_data;
                    valid_next = left_valid;
                end else if (ins) begin
                    data_next  = ctl.key;
                    valid_next = 1'b1;
                end
            end
            tmq_pkg::CELL_REMOVE: begin
                if (chain) begin
                    data_next  = right_data;
                    valid_next = right_valid;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign data  = data_reg;
    assign valid = valid_reg;

endmodule

// File: rtl/core/timer_expiry_queue.sv
// Timer expiry queue: a row of TIMER_SLOTS cells holding active timers sorted
// by expiry time, earliest in cell 0, equal expiries in arrival order.
// Input channel (s_valid/s_ready) carries one word per command: add, delete,
// tick or query. Result channel (m_valid/m_ready) returns result words, each
// flagged m_last on the final word caused by a command.
// Add, delete and query are handled in the accept cycle: the cell row updates
// at its end and the single result word is presented on the next cycle.
// A tick walks the head of the row: it pops each expired timer, re-arms it in
// the ST_REARM state when its interval is non-zero, and ends when it finds the
// head unexpired.
// A tick with nothing expired returns no word.
// The rate is set by the single output register, which a stalled receiver holds,
// and by the cell row taking one insert or one removal per cycle.
// s_ready is high only when the sequencer is idle and the output register
// is empty or being drained this cycle; a stalled receiver holds the result
// word and freezes the tick walk until it is taken.
// Reset (synchronous, aresetn low) empties the row, sets the id counter to
// one and the default timeout to 10000; cfg_we writes the default timeout.
module timer_expiry_queue #(
    parameter int unsigned TIMER_SLOTS = tmq_pkg::TIMER_SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [31:0] s_now_ms,
    input  logic [31:0] s_expire_ms,
    input  logic [30:0] s_repeat_ms,
    input  logic [31:0] s_target_id,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [31:0] m_id_out,
    output logic [31:0] m_duration_ms,
    output logic [1:0]  m_status,
    output logic        m_last
);

    tmq_pkg::cell_ctl_t ctl;
    logic               chain_head;
    tmq_pkg::slot_t     cell_data  [TIMER_SLOTS];
    logic               cell_valid [TIMER_SLOTS];
    logic               cell_ins   [TIMER_SLOTS];
    logic               cell_chain [TIMER_SLOTS];

    // Row of cells: each links to its left and right neighbour.
    for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
        tmq_pkg::slot_t ld, rd;
        logic lv, li, lc, rv;
        if (i == 0) begin : g_first
            assign ld = '0;
            assign lv = 1'b0;
            assign li = 1'b0;
            assign lc = chain_head;
        end else begin : g_mid
            assign ld = cell_data[i-1];
            assign lv = cell_valid[i-1];
            assign li = cell_ins[i-1];
            assign lc = cell_chain[i-1];
        end
        if (i == TIMER_SLOTS - 1) begin : g_last
            assign rd = '0;
            assign rv = 1'b0;
        end else begin : g_inner
            assign rd = cell_data[i+1];
            assign rv = cell_valid[i+1];
        end
        tmq_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .left_data  (ld),
            .left_valid (lv),
            .left_ins   (li),
            .left_chain (lc),
            .right_data (rd),
            .right_valid(rv),
            .data       (cell_data[i]),
            .valid      (cell_valid[i]),
            .ins        (cell_ins[i]),
            .chain      (cell_chain[i])
        );
    end

    tmq_pkg::state_t state_reg, state_next;
    logic [31:0] default_timeout_reg;
    logic [31:0] next_ident_reg, next_ident_next;
    logic [31:0] now_reg, now_next;
    logic [31:0] pend_id_reg, pend_id_next;
    logic [30:0] pend_iv_reg, pend_iv_next;

    logic        m_valid_reg, m_valid_next;
    logic [1:0]  m_kind_reg, m_kind_next;
    logic [31:0] m_id_reg, m_id_next;
    logic [31:0] m_dur_reg, m_dur_next;
    logic [1:0]  m_status_reg, m_status_next;
    logic        m_last_reg, m_last_next;

    logic        out_free, accept, load, full, head_expired;
    logic [32:0] rearm_sum;
    logic [31:0] rearm_exp;

    assign out_free     = !m_valid_reg || m_ready;
    assign s_ready      = (state_reg == tmq_pkg::ST_IDLE) && out_free;
    assign accept       = s_valid && s_ready;
    assign full         = cell_valid[TIMER_SLOTS-1];
    assign head_expired = cell_valid[0] && (cell_data[0].expiry < now_reg);
    // Saturate the re-arm time at the top of the clock range.
    assign rearm_sum    = {1'b0, now_reg} + {2'b00, pend_iv_reg};
    assign rearm_exp    = rearm_sum[32] ? '1 : rearm_sum[31:0];

    always_comb begin
        state_next      = state_reg;
        next_ident_next = next_ident_reg;
        now_next        = now_reg;
        pend_id_next    = pend_id_reg;
        pend_iv_next    = pend_iv_reg;
        ctl.op          = tmq_pkg::CELL_HOLD;
        ctl.key         = '0;
        chain_head      = 1'b0;
        load            = 1'b0;
        m_kind_next     = m_kind_reg;
        m_id_next       = m_id_reg;
        m_dur_next      = m_dur_reg;
        m_status_next   = m_status_reg;
        m_last_next     = m_last_reg;

        unique case (state_reg)
            tmq_pkg::ST_IDLE: begin
                if (accept) begin
                    m_dur_next    = '0;
                    m_status_next = tmq_pkg::STATUS_OK;
                    m_last_next   = 1'b1;
                    unique case (tmq_pkg::action_t'(s_action))
                        tmq_pkg::ACT_ADD: begin
                            load        = 1'b1;
                            m_kind_next = tmq_pkg::KIND_ADD_ACK;
                            if (full) begin
                                m_id_next     = '0;
                                m_status_next = tmq_pkg::STATUS_FULL;
                            end else begin
                                ctl.op           = tmq_pkg::CELL_INSERT;
                                ctl.key.expiry   = s_expire_ms;
                                ctl.key.interval = s_repeat_ms;
                                ctl.key.ident    = next_ident_reg;
                                m_id_next        = next_ident_reg;
                                next_ident_next  = next_ident_reg + 32'd1;
                            end
                        end
                        tmq_pkg::ACT_DELETE: begin
                            // Close the gap behind the first matching cell.
                            load          = 1'b1;
                            ctl.op        = tmq_pkg::CELL_REMOVE;
                            ctl.key.ident = s_target_id;
                            m_kind_next   = tmq_pkg::KIND_DELETE_ACK;
                            m_id_next     = s_target_id;
                            if (!cell_chain[TIMER_SLOTS-1]) begin
                                m_status_next = tmq_pkg::STATUS_NOT_ACTIVE;
                            end
                        end
                        tmq_pkg::ACT_TICK: begin
                            now_next   = s_now_ms;
                            state_next = tmq_pkg::ST_TICK;
                        end
                        tmq_pkg::ACT_QUERY: begin
                            load        = 1'b1;
                            m_kind_next = tmq_pkg::KIND_DURATION;
                            m_id_next   = '0;
                            if (!cell_valid[0]) begin
                                m_dur_next = default_timeout_reg;
                            end else if (cell_data[0].expiry > s_now_ms) begin
                                m_dur_next = cell_data[0].expiry - s_now_ms;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            tmq_pkg::ST_TICK: begin
                if (!head_expired) begin
                    state_next = tmq_pkg::ST_IDLE;
                end else if (out_free) begin
                    // Pop the head; re-armed entries never expire within this tick.
                    load          = 1'b1;
                    ctl.op        = tmq_pkg::CELL_REMOVE;
                    chain_head    = 1'b1;
                    m_kind_next   = tmq_pkg::KIND_EXPIRED;
                    m_id_next     = cell_data[0].ident;
                    m_dur_next    = '0;
                    m_status_next = tmq_pkg::STATUS_OK;
                    m_last_next   = !(cell_valid[1] && (cell_data[1].expiry < now_reg));
                    pend_id_next  = cell_data[0].ident;
                    pend_iv_next  = cell_data[0].interval;
                    if (cell_data[0].interval != '0) begin
                        state_next = tmq_pkg::ST_REARM;
                    end
                end
            end
            tmq_pkg::ST_REARM: begin
                ctl.op           = tmq_pkg::CELL_INSERT;
                ctl.key.expiry   = rearm_exp;
                ctl.key.interval = pend_iv_reg;
                ctl.key.ident    = pend_id_reg;
                state_next       = tmq_pkg::ST_TICK;
            end
            default: begin
                state_next = tmq_pkg::ST_IDLE;
            end
        endcase

        m_valid_next = load ? 1'b1 : (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        now_reg      <= now_next;
        pend_id_reg  <= pend_id_next;
        pend_iv_reg  <= pend_iv_next;
        m_kind_reg   <= m_kind_next;
        m_id_reg     <= m_id_next;
        m_dur_reg    <= m_dur_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
        if (!aresetn) begin
            state_reg           <= tmq_pkg::ST_IDLE;
            next_ident_reg      <= tmq_pkg::IDENT_RST;
            default_timeout_reg <= tmq_pkg::DEFAULT_TIMEOUT_RST;
            m_valid_reg         <= 1'b0;
        end else begin
            state_reg      <= state_next;
            next_ident_reg <= next_ident_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_we) begin
                default_timeout_reg <= cfg_wdata;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = m_kind_reg;
    assign m_id_out      = m_id_reg;
    assign m_duration_ms = m_dur_reg;
    assign m_status      = m_status_reg;
    assign m_last        = m_last_reg;

endmodule

// File: rtl/core/tmq_checker.sv
`include "timer_expiry_queue_assert.svh"

module tmq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [1:0]  s_action,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_kind,
    input logic [31:0] m_id_out,
    input logic        m_last
);

    // Hold a stalled result word.
    `TEQ_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_id_out))
    // Accept a word only when the output register can take its result.
    `TEQ_ASSERT_IMPL(a_ready_room, aclk, aresetn, s_ready, !m_valid || m_ready)
    // Answer every non-tick word with one final result next cycle.
    `TEQ_ASSERT_NEXT(a_single_result, aclk, aresetn,
        s_valid && s_ready && (s_action != tmq_pkg::ACT_TICK), m_valid && m_last)
    // Drive a zero id on duration results.
    `TEQ_ASSERT_IMPL(a_query_id, aclk, aresetn,
        m_valid && (m_kind == tmq_pkg::KIND_DURATION), m_id_out == '0)

endmodule

bind timer_expiry_queue tmq_checker u_tmq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_action(s_action),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_kind  (m_kind),
    .m_id_out(m_id_out),
    .m_last  (m_last)
);

// File: tb/sv/timer_expiry_queue_checker.sv
module timer_expiry_queue_checker
    import tmq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [31:0] s_now_ms,
    input  logic [31:0] s_expire_ms,
    input  logic [30:0] s_repeat_ms,
    input  logic [31:0] s_target_id,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_kind,
    input  logic [31:0] m_id_out,
    input  logic [31:0] m_duration_ms,
    input  logic [1:0]  m_status,
    input  logic        m_last,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = TIMER_SLOTS_DEF;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] id;
        logic [31:0] dur;
        logic [1:0]  status;
        logic        last;
    } result_t;

    result_t     due_q[$];
    slot_t       row[SLOTS];
    int          used;
    logic [31:0] next_id;
    logic [31:0] dflt_timeout;

    assign pending = due_q.size();

    // Insert behind every entry of equal expiry.
    function automatic void place(slot_t t);
        int p;
        p = used;
        while (p > 0 && row[p-1].expiry > t.expiry) begin
            row[p] = row[p-1];
            p--;
        end
        row[p] = t;
        used++;
    endfunction

    function automatic void push(kind_t k, logic [31:0] id, logic [31:0] dur,
                                 logic [1:0] st, logic lst);
        result_t r;
        r.kind = k; r.id = id; r.dur = dur; r.status = st; r.last = lst;
        due_q.push_back(r);
    endfunction

    task automatic predict_command(logic [1:0] act, logic [31:0] now,
                                   logic [31:0] exp, logic [30:0] rep,
                                   logic [31:0] tgt);
        slot_t popped[$];
        slot_t t;
        int    hit;
        logic [32:0] sum;
        case (action_t'(act))
            ACT_ADD: begin
                if (used >= SLOTS) begin
                    push(KIND_ADD_ACK, 0, 0, STATUS_FULL, 1'b1);
                end else begin
                    t.expiry = exp; t.interval = rep; t.ident = next_id;
                    place(t);
                    push(KIND_ADD_ACK, next_id, 0, STATUS_OK, 1'b1);
                    next_id++;
                end
            end
            ACT_DELETE: begin
                hit = -1;
                for (int i = 0; i < used; i++)
                    if (hit < 0 && row[i].ident == tgt) hit = i;
                if (hit < 0) begin
                    push(KIND_DELETE_ACK, tgt, 0, STATUS_NOT_ACTIVE, 1'b1);
                end else begin
                    for (int k = hit; k + 1 < used; k++) row[k] = row[k+1];
                    used--;
                    push(KIND_DELETE_ACK, tgt, 0, STATUS_OK, 1'b1);
                end
            end
            ACT_TICK: begin
                while (used > 0 && row[0].expiry < now) begin
                    popped.push_back(row[0]);
                    for (int k = 0; k + 1 < used; k++) row[k] = row[k+1];
                    used--;
                end
                foreach (popped[i])
                    push(KIND_EXPIRED, popped[i].ident, 0, STATUS_OK,
                         i == popped.size() - 1);
                // Re-arm repeats in expiry order, saturating the sum.
                foreach (popped[i]) begin
                    if (popped[i].interval != 0) begin
                        t = popped[i];
                        sum = {1'b0, now} + {2'b0, t.interval};
                        t.expiry = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                        place(t);
                    end
                end
            end
            default: begin
                if (used == 0)
                    push(KIND_DURATION, 0, dflt_timeout, STATUS_OK, 1'b1);
                else
                    push(KIND_DURATION, 0,
                         row[0].expiry > now ? row[0].expiry - now : 32'd0,
                         STATUS_OK, 1'b1);
            end
        endcase
    endtask

    always @(posedge aclk) begin
        result_t e;
        if (!aresetn) begin
            used         = 0;
            next_id      = IDENT_RST;
            dflt_timeout = DEFAULT_TIMEOUT_RST;
            due_q.delete();
            errors       = 0;
        end else begin
            if (cfg_we) dflt_timeout = cfg_wdata;
            if (m_valid && m_ready) begin
                if (due_q.size() == 0) begin
                    $display("%0t: unexpected word kind=%0d id=%0d", $time,
                             m_kind, m_id_out);
                    errors++;
                end else begin
                    e = due_q.pop_front();
                    if (m_kind !== e.kind || m_id_out !== e.id ||
                        m_duration_ms !== e.dur || m_status !== e.status ||
                        m_last !== e.last) begin
                        $display("%0t: mismatch exp k=%0d id=%0d dur=%0d st=%0d l=%0d",
                                 $time, e.kind, e.id, e.dur, e.status, e.last);
                        $display("%0t:          got k=%0d id=%0d dur=%0d st=%0d l=%0d",
                                 $time, m_kind, m_id_out, m_duration_ms,
                                 m_status, m_last);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready)
                predict_command(s_action, s_now_ms, s_expire_ms, s_repeat_ms,
                                s_target_id);
        end
    end

    initial errors = 0;
endmodule

// File: tb/sv/timer_expiry_queue_tb.sv
module timer_expiry_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tmq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action = ACT_QUERY;
    logic [31:0] s_now_ms = '0;
    logic [31:0] s_expire_ms = '0;
    logic [30:0] s_repeat_ms = '0;
    logic [31:0] s_target_id = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [31:0] m_id_out;
    logic [31:0] m_duration_ms;
    logic [1:0]  m_status;
    logic        m_last;
    int          errors, pending;
    int          cycles = 0;

    // Receiver behaviour, steered from the stimulus process.
    bit          sink_calm = 1'b0;
    bit          sink_hold = 1'b0;
    logic [31:0] clock_ms = 32'd1000;
    logic [31:0] last_id = 32'd1;

    always #4 aclk = ~aclk;

    timer_expiry_queue uut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_now_ms(s_now_ms), .s_expire_ms(s_expire_ms),
        .s_repeat_ms(s_repeat_ms), .s_target_id(s_target_id),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind),
        .m_id_out(m_id_out), .m_duration_ms(m_duration_ms),
        .m_status(m_status), .m_last(m_last)
    );

    timer_expiry_queue_checker chk (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_now_ms(s_now_ms), .s_expire_ms(s_expire_ms),
        .s_repeat_ms(s_repeat_ms), .s_target_id(s_target_id),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind),
        .m_id_out(m_id_out), .m_duration_ms(m_duration_ms),
        .m_status(m_status), .m_last(m_last),
        .errors(errors), .pending(pending)
    );

    // Drop the whole run if it hangs.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: stall at random unless calm; a long hold-off counted here.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (sink_hold && hold_left == 0) hold_left = 300;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
                if (hold_left == 0) sink_hold = 1'b0;
            end else begin
                m_ready <= sink_calm ? 1'b1 : ($urandom_range(99) >= 25);
            end
        end
    end

    // Offer one word and hold it until taken; valid stays up for a
    // following word unless an idle cycle is drawn.
    task automatic send(logic [1:0] act, logic [31:0] now, logic [31:0] exp,
                        logic [30:0] rep, logic [31:0] tgt, bit gaps);
        while (gaps && $urandom_range(99) < 25) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_action    <= act;
        s_now_ms    <= now;
        s_expire_ms <= exp;
        s_repeat_ms <= rep;
        s_target_id <= tgt;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (2 * TIMER_SLOTS_DEF + 8) @(posedge aclk);
    endtask

    task automatic write_timeout(logic [31:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly plausible traffic near the running clock, some raw noise.
    task automatic random_word(bit gaps);
        logic [1:0]  act;
        logic [31:0] exp, tgt;
        logic [30:0] rep;
        act = 2'($urandom_range(3));
        if ($urandom_range(9) == 0) begin
            exp = $urandom; tgt = $urandom; rep = 31'($urandom);
            send(act, $urandom, exp, rep, tgt, gaps);
        end else begin
            clock_ms = clock_ms + $urandom_range(40);
            exp = clock_ms + $urandom_range(120);
            rep = ($urandom_range(2) == 0) ? 31'd0 : 31'($urandom_range(90));
            tgt = ($urandom_range(4) == 0) ? $urandom
                                           : last_id - $urandom_range(20);
            if (act == ACT_ADD) last_id = last_id + 1;
            send(act, clock_ms, exp, rep, tgt, gaps);
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty query with the reset default, then field extremes.
        sink_calm = 1'b1;
        send(ACT_QUERY, 0, 0, 0, 0, 0);
        send(ACT_TICK, 32'hFFFF_FFFF, 0, 0, 0, 0);
        send(ACT_DELETE, 0, 0, 0, 32'hFFFF_FFFF, 0);
        send(ACT_ADD, 0, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 0, 0);
        send(ACT_ADD, 0, 32'd0, 31'd0, 0, 0);
        send(ACT_ADD, 0, 32'd50, 31'd10, 0, 0);
        send(ACT_ADD, 0, 32'd50, 31'd0, 0, 0);
        send(ACT_QUERY, 32'd100, 0, 0, 0, 0);
        send(ACT_QUERY, 32'd20, 0, 0, 0, 0);
        send(ACT_DELETE, 0, 0, 0, 32'd3, 0);
        send(ACT_DELETE, 0, 0, 0, 32'd3, 0);
        // Tick at the top of the clock range: all expire but the timer at the top.
        send(ACT_TICK, 32'hFFFF_FFFF, 0, 0, 0, 0);
        send(ACT_TICK, 32'd10, 0, 0, 0, 0);
        write_timeout(32'd0);
        send(ACT_DELETE, 0, 0, 0, 32'd1, 0);
        send(ACT_DELETE, 0, 0, 0, 32'd3, 0);
        send(ACT_QUERY, 32'd5, 0, 0, 0, 0);
        write_timeout(32'hFFFF_FFFF);
        send(ACT_QUERY, 32'd5, 0, 0, 0, 0);
        // Fill the table past full, then expire it all in one tick.
        for (int i = 0; i < 18; i++)
            send(ACT_ADD, 0, 32'(i % 4), 31'(i % 3), 0, 0);
        send(ACT_TICK, 32'd100, 0, 0, 0, 0);
        drain();
        send(ACT_TICK, 32'd200, 0, 0, 0, 0);
        drain();

        // Restart from an empty table so ids track the random clock.
        for (int i = 1; i < 40; i++) send(ACT_DELETE, 0, 0, 0, i, 0);
        send(ACT_TICK, 32'hFFFF_FFFF, 0, 0, 0, 0);
        drain();
        send(ACT_TICK, 32'hFFFF_FFFF, 0, 0, 0, 0);
        write_timeout(32'd10000);
        clock_ms = 32'd1000;
        last_id  = 32'd25;

        // Random with idling on both sides.
        sink_calm = 1'b0;
        for (int i = 0; i < 100; i++) random_word(1'b1);
        // Long receiver hold-off while the sender keeps offering.
        sink_hold = 1'b1;
        for (int i = 0; i < 30; i++) random_word(1'b0);
        // Sender waits for every expected word.
        drain();
        write_timeout(32'd1);
        // Calm stretch with no idling on either side.
        sink_calm = 1'b1;
        for (int i = 0; i < 50; i++) random_word(1'b0);
        sink_calm = 1'b0;
        for (int i = 0; i < 20; i++) random_word(1'b1);

        drain();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
